// ----- rtl/core/rgb_matrix_dwell_scanner_top_assert.svh -----
// Assertion macros for the RGB matrix dwell scanner.
`ifndef RGB_MATRIX_DWELL_SCANNER_TOP_ASSERT_SVH
`define RGB_MATRIX_DWELL_SCANNER_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define RGBMDS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define RGBMDS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/rgbmds_pkg.sv -----
// Shared types and constants of the RGB matrix dwell scanner.
`default_nettype none
package rgbmds_pkg;

    localparam int LED_COUNT_DEF = 64;
    localparam int ROW_WIDTH_DEF = 8;

    localparam int LEVEL_W  = 8;
    localparam int INDEX_W  = 6;
    localparam int POS_W    = 6;
    localparam int DRIVE_W  = 8;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 40;

    localparam logic [LEVEL_W-1:0] BLANK_TICKS_RST = 8'd2;

    localparam logic [1:0] PHASE_RED   = 2'd0;
    localparam logic [1:0] PHASE_GREEN = 2'd1;
    localparam logic [1:0] PHASE_BLUE  = 2'd2;
    localparam logic [1:0] PHASE_BLANK = 2'd3;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef struct packed {
        logic [LEVEL_W-1:0] blue;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] red;
    } levels_t;

endpackage
`default_nettype wire

// ----- rtl/core/rgbmds_store.sv -----
// Level store: one write port, two registered read ports, per-entry valid bits.
`default_nettype none
module rgbmds_store
    import rgbmds_pkg::*;
#(
    parameter int LED_COUNT = LED_COUNT_DEF,
    localparam int AW = $clog2(LED_COUNT)
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire levels_t       wr_levels,
    input  wire logic [AW-1:0] rd_addr_a,
    input  wire logic [AW-1:0] rd_addr_b,
    output levels_t            rd_levels_a,
    output levels_t            rd_levels_b
);

    levels_t                 mem [LED_COUNT];
    logic [LED_COUNT-1:0]    valid_reg;
    levels_t                 rd_a_reg;
    levels_t                 rd_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_levels;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // write-first: a write to the address being read shows up at once
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_a_reg <= '0;
            rd_b_reg <= '0;
        end else begin
            if (wr_en && (wr_addr == rd_addr_a)) begin
                rd_a_reg <= wr_levels;
            end else if (valid_reg[rd_addr_a]) begin
                rd_a_reg <= mem[rd_addr_a];
            end else begin
                rd_a_reg <= '0;
            end
            if (wr_en && (wr_addr == rd_addr_b)) begin
                rd_b_reg <= wr_levels;
            end else if (valid_reg[rd_addr_b]) begin
                rd_b_reg <= mem[rd_addr_b];
            end else begin
                rd_b_reg <= '0;
            end
        end
    end

    assign rd_levels_a = rd_a_reg;
    assign rd_levels_b = rd_b_reg;

endmodule
`default_nettype wire

// ----- rtl/core/rgbmds_skid.sv -----
// Result register with a skid stage; the producer waits only while it is full.
`default_nettype none
module rgbmds_skid
    import rgbmds_pkg::*;
#(
    parameter int DW = M_DATA_W
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    input  wire logic [DW-1:0] in_data,
    output logic               in_ready,
    output logic               out_valid,
    output logic [DW-1:0]      out_data,
    input  wire logic          out_ready
);

    logic          out_valid_reg;
    logic [DW-1:0] out_data_reg;
    logic          skid_valid_reg;
    logic [DW-1:0] skid_data_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_ready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                out_data_reg   <= skid_data_reg;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= in_valid;
                out_data_reg   <= in_data;
            end
        end else if (in_valid && !skid_valid_reg) begin
            skid_valid_reg <= 1'b1;
            skid_data_reg  <= in_data;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/rgb_matrix_dwell_scanner_top.sv -----
// Top level of the RGB matrix dwell scanner.
`default_nettype none
// Scans an RGB LED matrix one LED and one colour at a time. Each input item
// is either a level write (tuser low: store red, green and blue dwell levels
// for led_index) or a one-microsecond tick (tuser high), which yields one
// result item telling which row and which colour column are lit during that
// tick. Writes yield nothing; a led_index beyond LED_COUNT-1 is dropped.
// Rate: one item per clock, for any mix of writes and ticks, while the skid
// stage is empty. The decision for a tick is a short choice among the
// registered levels of the current LED and the next LED; both are read
// every cycle from the level store's two registered read ports, addressed by
// the next scan position, with write-first bypass so a write is seen by the
// very next tick. The result goes through an output register plus a skid
// stage; s_tready drops only while the skid stage holds an item. Store reset
// needs no clearing pass: per-entry valid bits make unwritten LEDs read as
// zero. blank_ticks (cfg_wr_data, reset 2, zero acts as one) sets how long
// an all-dark LED is held. The first tick after reset serves LED 1.
module rgb_matrix_dwell_scanner_top
    import rgbmds_pkg::*;
#(
    parameter int LED_COUNT = LED_COUNT_DEF,
    parameter int ROW_WIDTH = ROW_WIDTH_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // config: blank_ticks
    input  wire logic                cfg_wr_en,
    input  wire logic [LEVEL_W-1:0]  cfg_wr_data,
    // input items
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // [5:0] led_index, [13:6] red_level, [21:14] green_level,
    // [29:22] blue_level, [31:30] zero
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // [0] operation
    input  wire logic                s_tuser,
    // result items
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // [7:0] row_drive, [15:8] red_columns, [23:16] green_columns,
    // [31:24] blue_columns, [37:32] scan_position, [39:38] color_phase
    output logic [M_DATA_W-1:0]      m_tdata
);

    localparam int SW = $clog2(LED_COUNT);
    localparam int CW = $clog2(ROW_WIDTH);
    localparam int IW = (SW > INDEX_W) ? SW : INDEX_W;
    localparam logic [SW-1:0] LAST_LED = SW'(LED_COUNT - 1);
    localparam logic [CW-1:0] LAST_COL = CW'(ROW_WIDTH - 1);

    // input fields
    logic [INDEX_W-1:0] led_index;
    levels_t            in_levels;
    logic [IW-1:0]      index_wide;

    assign led_index       = s_tdata[INDEX_W-1:0];
    assign in_levels.red   = s_tdata[INDEX_W +: LEVEL_W];
    assign in_levels.green = s_tdata[INDEX_W+LEVEL_W +: LEVEL_W];
    assign in_levels.blue  = s_tdata[INDEX_W+2*LEVEL_W +: LEVEL_W];
    assign index_wide      = IW'(led_index);

    logic s_acc;
    logic tick;
    logic wr_en;

    assign s_acc = s_tvalid && s_tready;
    assign tick  = s_acc && (s_tuser == OP_TICK);
    assign wr_en = s_acc && (s_tuser == OP_WRITE) && (32'(led_index) < LED_COUNT);

    // scan state
    logic [LEVEL_W-1:0] blank_ticks_reg;
    logic [SW-1:0]      scan_reg, scan_next;
    logic [SW-1:0]      row_reg, row_next;
    logic [CW-1:0]      col_reg, col_next;
    logic [1:0]         phase_reg, phase_next;
    logic [LEVEL_W-1:0] dwell_reg, dwell_next;

    levels_t cur_levels;
    levels_t nxt_levels;

    logic [SW-1:0] rd_addr_a;
    logic [SW-1:0] rd_addr_b;

    rgbmds_store #(
        .LED_COUNT (LED_COUNT)
    ) u_store (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .wr_en       (wr_en),
        .wr_addr     (index_wide[SW-1:0]),
        .wr_levels   (in_levels),
        .rd_addr_a   (rd_addr_a),
        .rd_addr_b   (rd_addr_b),
        .rd_levels_a (cur_levels),
        .rd_levels_b (nxt_levels)
    );

    // phase choice for this tick
    logic               advance;
    logic [1:0]         phase_sel;
    logic [LEVEL_W-1:0] load_sel;
    logic [SW-1:0]      scan_inc;
    logic [SW-1:0]      scan_sel;
    logic [SW-1:0]      row_sel;
    logic [CW-1:0]      col_sel;
    logic [LEVEL_W-1:0] blank_len;

    assign scan_inc  = (scan_reg == LAST_LED) ? '0 : scan_reg + 1'b1;
    assign blank_len = (blank_ticks_reg == '0) ? LEVEL_W'(1) : blank_ticks_reg;

    always_comb begin
        advance   = 1'b0;
        phase_sel = phase_reg;
        load_sel  = dwell_reg;
        if (dwell_reg == '0) begin
            if ((phase_reg == PHASE_RED) && (cur_levels.green != '0)) begin
                phase_sel = PHASE_GREEN;
                load_sel  = cur_levels.green;
            end else if (((phase_reg == PHASE_RED) || (phase_reg == PHASE_GREEN))
                         && (cur_levels.blue != '0)) begin
                phase_sel = PHASE_BLUE;
                load_sel  = cur_levels.blue;
            end else begin
                advance = 1'b1;
                if (nxt_levels.red != '0) begin
                    phase_sel = PHASE_RED;
                    load_sel  = nxt_levels.red;
                end else if (nxt_levels.green != '0) begin
                    phase_sel = PHASE_GREEN;
                    load_sel  = nxt_levels.green;
                end else if (nxt_levels.blue != '0) begin
                    phase_sel = PHASE_BLUE;
                    load_sel  = nxt_levels.blue;
                end else begin
                    phase_sel = PHASE_BLANK;
                    load_sel  = blank_len;
                end
            end
        end
    end

    // row/column tracked as counters alongside the scan index
    always_comb begin
        scan_sel = scan_reg;
        row_sel  = row_reg;
        col_sel  = col_reg;
        if (advance) begin
            scan_sel = scan_inc;
            if (scan_reg == LAST_LED) begin
                row_sel = '0;
                col_sel = '0;
            end else if (col_reg == LAST_COL) begin
                row_sel = row_reg + 1'b1;
                col_sel = '0;
            end else begin
                col_sel = col_reg + 1'b1;
            end
        end
    end

    assign scan_next  = tick ? scan_sel : scan_reg;
    assign row_next   = tick ? row_sel : row_reg;
    assign col_next   = tick ? col_sel : col_reg;
    assign phase_next = tick ? phase_sel : phase_reg;
    assign dwell_next = tick ? load_sel - 1'b1 : dwell_reg;

    // prefetch levels for the LED served next cycle and the one after
    assign rd_addr_a = scan_next;
    assign rd_addr_b = (scan_next == LAST_LED) ? '0 : scan_next + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blank_ticks_reg <= BLANK_TICKS_RST;
            scan_reg        <= '0;
            row_reg         <= '0;
            col_reg         <= '0;
            phase_reg       <= PHASE_BLANK;
            dwell_reg       <= '0;
        end else begin
            if (cfg_wr_en) begin
                blank_ticks_reg <= cfg_wr_data;
            end
            scan_reg  <= scan_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            phase_reg <= phase_next;
            dwell_reg <= dwell_next;
        end
    end

    // result item
    logic [DRIVE_W-1:0] row_hot;
    logic [DRIVE_W-1:0] col_hot;
    logic [DRIVE_W-1:0] row_drive;
    logic [DRIVE_W-1:0] red_columns;
    logic [DRIVE_W-1:0] green_columns;
    logic [DRIVE_W-1:0] blue_columns;
    logic [IW-1:0]      scan_wide;
    logic [M_DATA_W-1:0] res_data;
    logic               res_ready;

    assign row_hot = (32'(row_sel) < DRIVE_W) ? (DRIVE_W'(1) << row_sel) : '0;
    assign col_hot = (32'(col_sel) < DRIVE_W) ? (DRIVE_W'(1) << col_sel) : '0;

    assign row_drive     = (phase_sel == PHASE_BLANK) ? '0 : row_hot;
    assign red_columns   = (phase_sel == PHASE_RED)   ? col_hot : '0;
    assign green_columns = (phase_sel == PHASE_GREEN) ? col_hot : '0;
    assign blue_columns  = (phase_sel == PHASE_BLUE)  ? col_hot : '0;
    assign scan_wide     = IW'(scan_sel);

    assign res_data = {phase_sel, scan_wide[POS_W-1:0], blue_columns,
                       green_columns, red_columns, row_drive};

    rgbmds_skid #(
        .DW (M_DATA_W)
    ) u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (tick),
        .in_data   (res_data),
        .in_ready  (res_ready),
        .out_valid (m_tvalid),
        .out_data  (m_tdata),
        .out_ready (m_tready)
    );

    assign s_tready = res_ready;

`include "rgb_matrix_dwell_scanner_top_assert.svh"

    // a running dwell never moves the scan
    `RGBMDS_ASSERT_NEXT(a_dwell_holds_scan, tick && (dwell_reg != '0), scan_reg == $past(scan_reg), "scan moved mid-dwell")
    // a running blank stays blank
    `RGBMDS_ASSERT_NEXT(a_blank_holds, tick && (dwell_reg != '0) && (phase_reg == PHASE_BLANK), phase_reg == PHASE_BLANK, "blank left early")
    // blank drives nothing
    `RGBMDS_ASSERT_NOW(a_blank_dark, m_tvalid && (m_tdata[39:38] == PHASE_BLANK), m_tdata[31:0] == '0, "drive during blank")
    // never more than one colour column group lit
    `RGBMDS_ASSERT_NOW(a_one_colour, m_tvalid, $onehot0({|m_tdata[31:24], |m_tdata[23:16], |m_tdata[15:8]}), "two colours lit")

endmodule
`default_nettype wire

// ----- tb/sv/tb_rgb_matrix_dwell_scanner_top.sv -----
// Self-checking testbench for the RGB matrix dwell scanner: directed and random items, scoreboard.
`default_nettype none
module tb_rgb_matrix_dwell_scanner_top;
    import rgbmds_pkg::*;

    localparam int DRAIN_CYCLES  = 8;     // output register + skid, with margin
    localparam int STALL_LIMIT   = 2000;  // cycles with no handshake before giving up
    localparam int REPORT_LIMIT  = 10;

    // Result layout, lowest field last in the list.
    typedef struct packed {
        logic [1:0]         colour;
        logic [POS_W-1:0]   pos;
        logic [DRIVE_W-1:0] blue_cols;
        logic [DRIVE_W-1:0] green_cols;
        logic [DRIVE_W-1:0] red_cols;
        logic [DRIVE_W-1:0] rows;
    } scan_out_t;

    logic                aclk;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [LEVEL_W-1:0]  cfg_wr_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    rgb_matrix_dwell_scanner_top DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // Scan state as the testbench sees it.
    levels_t            led_levels [LED_COUNT_DEF];
    logic [POS_W-1:0]   cur_led;
    logic [1:0]         cur_colour;
    int unsigned        dwell_rem;
    logic [LEVEL_W-1:0] blank_len;

    scan_out_t pending_scans [$];

    int errors;
    int n_reported;
    int n_writes;
    int n_ticks;
    int n_checked;
    int n_wraps;
    int src_idle_pct;
    int sink_stall_pct;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [LEVEL_W-1:0] level_for(logic [POS_W-1:0] led, int colour);
        case (colour)
            PHASE_RED:   return led_levels[led].red;
            PHASE_GREEN: return led_levels[led].green;
            default:     return led_levels[led].blue;
        endcase
    endfunction

    // Pick the next dwell: a later colour of this LED, else the next LED.
    function automatic void choose_dwell();
        int c;
        if (cur_colour == PHASE_RED || cur_colour == PHASE_GREEN) begin
            for (c = int'(cur_colour) + 1; c <= PHASE_BLUE; c++) begin
                if (level_for(cur_led, c) != '0) begin
                    cur_colour = c[1:0];
                    dwell_rem  = level_for(cur_led, c);
                    return;
                end
            end
        end
        cur_led = cur_led + 1'b1;
        if (cur_led == '0)
            n_wraps++;
        for (c = PHASE_RED; c <= PHASE_BLUE; c++) begin
            if (level_for(cur_led, c) != '0) begin
                cur_colour = c[1:0];
                dwell_rem  = level_for(cur_led, c);
                return;
            end
        end
        cur_colour = PHASE_BLANK;
        dwell_rem  = (blank_len == '0) ? 1 : blank_len;
    endfunction

    function automatic void predict_scan_step(logic op, logic [INDEX_W-1:0] idx, levels_t lv);
        scan_out_t want;
        logic [DRIVE_W-1:0] row_hot;
        logic [DRIVE_W-1:0] col_hot;
        if (op == OP_WRITE) begin
            led_levels[idx] = lv;
            n_writes++;
            return;
        end
        n_ticks++;
        if (dwell_rem == 0)
            choose_dwell();
        row_hot = DRIVE_W'(1) << cur_led[5:3];
        col_hot = DRIVE_W'(1) << cur_led[2:0];
        want            = '0;
        want.colour     = cur_colour;
        want.pos        = cur_led;
        if (cur_colour != PHASE_BLANK)
            want.rows = row_hot;
        if (cur_colour == PHASE_RED)
            want.red_cols = col_hot;
        if (cur_colour == PHASE_GREEN)
            want.green_cols = col_hot;
        if (cur_colour == PHASE_BLUE)
            want.blue_cols = col_hot;
        pending_scans.push_back(want);
        dwell_rem--;
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------
    task automatic push_item(input logic op, input logic [INDEX_W-1:0] idx, input levels_t lv);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {2'b00, lv, idx};
        do
            @(posedge aclk);
        while (!s_tready);
        predict_scan_step(op, idx, lv);
    endtask

    task automatic send_tick();
        levels_t junk;
        junk = 24'($urandom);
        push_item(OP_TICK, INDEX_W'($urandom_range(63)), junk);
    endtask

    task automatic send_write(input logic [INDEX_W-1:0] idx,
                              input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        levels_t lv;
        lv.red   = r;
        lv.green = g;
        lv.blue  = b;
        push_item(OP_WRITE, idx, lv);
    endtask

    // Stop sending and let every outstanding result come out.
    task automatic settle_scanner();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_scans.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_blank_len(input logic [LEVEL_W-1:0] v);
        settle_scanner();
        @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = v;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
        blank_len   = v;
    endtask

    // Receiver back-pressure
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready = ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic flag_mismatch(input string what, input logic [7:0] want, input logic [7:0] seen);
        errors++;
        if (n_reported < REPORT_LIMIT) begin
            n_reported++;
            $display("MISMATCH %s: expected 0x%02h, got 0x%02h (result %0d)",
                     what, want, seen, n_checked);
        end
    endtask

    always @(posedge aclk) begin
        scan_out_t seen;
        scan_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            seen = m_tdata;
            if (pending_scans.size() == 0) begin
                errors++;
                if (n_reported < REPORT_LIMIT) begin
                    n_reported++;
                    $display("UNEXPECTED result 0x%010h with nothing pending", m_tdata);
                end
            end else begin
                want = pending_scans.pop_front();
                if (seen.rows !== want.rows)
                    flag_mismatch("row_drive", want.rows, seen.rows);
                if (seen.red_cols !== want.red_cols)
                    flag_mismatch("red_columns", want.red_cols, seen.red_cols);
                if (seen.green_cols !== want.green_cols)
                    flag_mismatch("green_columns", want.green_cols, seen.green_cols);
                if (seen.blue_cols !== want.blue_cols)
                    flag_mismatch("blue_columns", want.blue_cols, seen.blue_cols);
                if (seen.pos !== want.pos)
                    flag_mismatch("scan_position", 8'(want.pos), 8'(seen.pos));
                if (seen.colour !== want.colour)
                    flag_mismatch("color_phase", 8'(want.colour), 8'(seen.colour));
                n_checked++;
            end
        end
    end

    // Watchdog: any handshake or register write restarts the count.
    initial begin
        int idle_run;
        idle_run = 0;
        while (idle_run < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
                idle_run = 0;
            else
                idle_run++;
        end
        $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty store, default blank length: first tick already serves LED 1.
    task automatic test_first_tick();
        repeat (3) send_tick();
    endtask

    // Index and level extremes, overwrite, colour skipping.
    task automatic test_level_extremes();
        send_write(6'd63, 8'hff, 8'hff, 8'hff);
        send_write(6'd63, 8'h00, 8'h01, 8'h00);
        send_write(6'd0, 8'h00, 8'h00, 8'h00);
        send_write(6'd3, 8'h01, 8'h00, 8'h02);
        send_write(6'd4, 8'h00, 8'h00, 8'h01);
        repeat (5) send_tick();
    endtask

    // Rewriting the LED being served leaves its running dwell alone.
    task automatic test_write_during_dwell();
        logic [POS_W-1:0] target;
        int guard;
        target = cur_led + 1'b1;
        send_write(target, 8'd3, 8'd2, 8'd0);
        guard = 0;
        do begin
            send_tick();
            guard++;
        end while (!(cur_led == target && cur_colour == PHASE_RED) && guard < 8);
        send_write(target, 8'd0, 8'd0, 8'd5);
        repeat (3) send_tick();
    endtask

    // A blank length of zero behaves as one.
    task automatic test_blank_zero();
        set_blank_len(8'd0);
        repeat (3) send_tick();
    endtask

    function automatic logic [7:0] rand_level();
        int pick;
        pick = $urandom_range(99);
        if (pick < 48)
            return 8'd0;
        if (pick < 97)
            return 8'($urandom_range(4, 1));
        return 8'($urandom_range(255));
    endfunction

    // Mixed writes and ticks; half the writes land at or just ahead of the scan.
    task automatic test_random_scan(input int n, input logic [7:0] blank,
                                    input int src_pct, input int sink_pct);
        logic [INDEX_W-1:0] idx;
        int i;
        set_blank_len(blank);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        for (i = 0; i < n; i++) begin
            if ($urandom_range(99) < 40) begin
                if ($urandom_range(1))
                    idx = cur_led + INDEX_W'($urandom_range(4, 0));
                else
                    idx = INDEX_W'($urandom_range(63));
                send_write(idx, rand_level(), rand_level(), rand_level());
            end else begin
                send_tick();
            end
        end
    endtask

    initial begin
        logic [7:0] mid_blank;
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = OP_WRITE;
        errors         = 0;
        n_reported     = 0;
        n_writes       = 0;
        n_ticks        = 0;
        n_checked      = 0;
        n_wraps        = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        foreach (led_levels[k])
            led_levels[k] = '0;
        cur_led    = '0;
        cur_colour = PHASE_BLANK;
        dwell_rem  = 0;
        blank_len  = BLANK_TICKS_RST;

        repeat (2) @(negedge aclk);
        aresetn = 1'b1;

        test_first_tick();
        test_level_extremes();
        test_write_during_dwell();
        test_blank_zero();

        mid_blank = 8'($urandom_range(40, 3));
        test_random_scan(190, 8'd1, 0, 0);
        test_random_scan(190, 8'd255, 78, 0);
        test_random_scan(190, mid_blank, 0, 78);
        test_random_scan(190, 8'($urandom_range(8, 1)), 15, 15);

        settle_scanner();
        if (pending_scans.size() != 0) begin
            errors++;
            $display("%0d expected results never arrived", pending_scans.size());
        end

        $display("Covered %0d level writes and %0d ticks, %0d results checked, %0d scan wraps",
                 n_writes, n_ticks, n_checked, n_wraps);
        $display("Blank lengths 0, 1, 2, %0d and 255 under four flow-control mixes", mid_blank);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
`default_nettype wire
